// File: rtl/sle_pkg.sv
package sle_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_INSERT = 3'd1;
    localparam logic [2:0] FUNC_DELETE = 3'd2;
    localparam logic [2:0] FUNC_SORT   = 3'd3;
    localparam logic [2:0] FUNC_SEARCH = 3'd4;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // one record as held in memory
    typedef struct packed {
        logic signed [31:0] code;
        logic [31:0]        payload;
    } rec_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        rec_t  wr_data;
    } mem_req_t;

endpackage

// File: rtl/sle_ram.sv
module sle_ram
(
    input  logic            clk,
    input  sle_pkg::mem_req_t req,
    output sle_pkg::rec_t   rd_data
);
    import sle_pkg::*;

    rec_t mem [LIST_DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// File: rtl/sle_seq.sv
module sle_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          func,
    input  logic signed [31:0]  key_code,
    input  logic [31:0]         new_payload,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [5:0]          position,
    output logic [31:0]         found_payload,
    output logic [6:0]          entry_count,
    output sle_pkg::mem_req_t   req,
    input  sle_pkg::rec_t       rd_data
);
    import sle_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;  // read entry i-1
    localparam logic [3:0] S_INS_WR = 4'd2;  // write it to i
    localparam logic [3:0] S_FND_RD = 4'd3;  // read entry i for search/delete
    localparam logic [3:0] S_FND_CK = 4'd4;  // compare
    localparam logic [3:0] S_DEL_RD = 4'd5;  // read entry i+1
    localparam logic [3:0] S_DEL_WR = 4'd6;  // write to i
    localparam logic [3:0] S_SRT_RI = 4'd7;  // read entry i
    localparam logic [3:0] S_SRT_RJ = 4'd8;  // latch i, read entry j
    localparam logic [3:0] S_SRT_CK = 4'd9;  // compare, maybe swap
    localparam logic [3:0] S_SRT_WJ = 4'd10; // write old i into j
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]  state_reg, state_next;
    cnt_t        count_reg, count_next;
    cnt_t        i_reg, i_next;
    cnt_t        j_reg, j_next;
    logic [2:0]  func_reg, func_next;
    logic signed [31:0] key_reg, key_next;
    logic [31:0] pay_reg, pay_next;
    rec_t        reci_reg, reci_next;
    logic [1:0]  status_reg, status_next;
    cnt_t        pos_reg, pos_next;
    logic [31:0] found_reg, found_next;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign position      = 6'(pos_reg);
    assign found_payload = found_reg;
    assign entry_count   = 7'(count_reg);

    // advance the sequencer one memory access at a time
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        reci_next   = reci_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        req         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    key_next    = key_code;
                    pay_next    = new_payload;
                    status_next = ST_DONE;
                    pos_next    = '0;
                    found_next  = '0;
                    state_next  = S_OUT;
                    priority case (func)
                        FUNC_CLEAR: count_next = '0;
                        FUNC_INSERT:
                        begin
                            if (count_reg >= cnt_t'(LIST_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                i_next     = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        FUNC_DELETE, FUNC_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = (func == FUNC_DELETE) ? ST_EMPTY : ST_NOTFOUND;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_FND_RD;
                            end
                        end
                        FUNC_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (count_reg > cnt_t'(1))
                            begin
                                i_next     = '0;
                                state_next = S_SRT_RI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (i_reg == '0)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = '0;
                    req.wr_data = '{code: key_reg, payload: pay_reg};
                    count_next  = count_reg + cnt_t'(1);
                    state_next  = S_OUT;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = addr_t'(i_reg - cnt_t'(1));
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = addr_t'(i_reg);
                req.wr_data = rd_data;
                i_next      = i_reg - cnt_t'(1);
                state_next  = S_INS_RD;
            end
            S_FND_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = addr_t'(i_reg);
                state_next  = S_FND_CK;
            end
            S_FND_CK:
            begin
                if (rd_data.code == key_reg)
                begin
                    if (func_reg == FUNC_SEARCH)
                    begin
                        pos_next   = i_reg;
                        found_next = rd_data.payload;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else if (i_reg + cnt_t'(1) >= count_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    i_next     = i_reg + cnt_t'(1);
                    state_next = S_FND_RD;
                end
            end
            S_DEL_RD:
            begin
                if (i_reg + cnt_t'(1) >= count_reg)
                begin
                    count_next = count_reg - cnt_t'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = addr_t'(i_reg + cnt_t'(1));
                    state_next  = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = addr_t'(i_reg);
                req.wr_data = rd_data;
                i_next      = i_reg + cnt_t'(1);
                state_next  = S_DEL_RD;
            end
            S_SRT_RI:
            begin
                if (i_reg + cnt_t'(1) >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = addr_t'(i_reg);
                    j_next      = i_reg + cnt_t'(1);
                    state_next  = S_SRT_RJ;
                end
            end
            S_SRT_RJ:
            begin
                // first pass latches entry i; later passes hold it in reci_reg
                if (j_reg == i_reg + cnt_t'(1))
                begin
                    reci_next = rd_data;
                end
                req.rd_en   = 1'b1;
                req.rd_addr = addr_t'(j_reg);
                state_next  = S_SRT_CK;
            end
            S_SRT_CK:
            begin
                if (rd_data.code < reci_reg.code)
                begin
                    // swap: new i takes entry j, old i goes to j next cycle
                    req.wr_en   = 1'b1;
                    req.wr_addr = addr_t'(i_reg);
                    req.wr_data = rd_data;
                    reci_next   = rd_data;
                    pay_next    = reci_reg.payload;
                    key_next    = reci_reg.code;
                    state_next  = S_SRT_WJ;
                end
                else if (j_reg + cnt_t'(1) >= count_reg)
                begin
                    i_next     = i_reg + cnt_t'(1);
                    state_next = S_SRT_RI;
                end
                else
                begin
                    j_next     = j_reg + cnt_t'(1);
                    state_next = S_SRT_RJ;
                end
            end
            S_SRT_WJ:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = addr_t'(j_reg);
                req.wr_data = '{code: key_reg, payload: pay_reg};
                if (j_reg + cnt_t'(1) >= count_reg)
                begin
                    i_next     = i_reg + cnt_t'(1);
                    state_next = S_SRT_RI;
                end
                else
                begin
                    j_next     = j_reg + cnt_t'(1);
                    state_next = S_SRT_RJ;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // hold working words
    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        reci_reg   <= reci_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(LIST_DEPTH))
        else $error("fill count beyond depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status_reg)))
        else $error("result lost under stall");
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> $stable(count_reg))
        else $error("count moved while idle");
    a_no_wr_oob: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (cnt_t'(req.wr_addr) <= count_reg))
        else $error("write beyond list end");
`endif

endmodule

// File: rtl/sequential_list_engine.sv
// Sequential list of up to LIST_DEPTH records (signed code, payload word).
// Input channel: in_valid/in_stall carrying func, key_code, new_payload.
// Output channel: out_valid/out_stall carrying status, position,
// found_payload, entry_count; one result word per input word.
// One operation runs at a time; in_stall is high from acceptance until the
// result has been taken. Records live in one single-port-read RAM with a
// registered read, so each entry moved or compared costs its own RAM access:
//   clear, unused codes, full/empty cases: result with no RAM access
//   insert: shift all n entries up one place, then write entry 0
//   search/delete: scan from entry 0; delete shifts later entries down
//   sort: n*(n-1)/2 compares, each maybe followed by a swap
// The RAM port is the limit on every path that moves or compares entries.
// Reset clears the entry count and the sequencer; RAM contents are not
// cleared and no clearing pass is needed. While out_stall is high the
// result is held unchanged and no new word is taken.
module sequential_list_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic signed [31:0] key_code,
    input  logic [31:0]        new_payload,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         position,
    output logic [31:0]        found_payload,
    output logic [6:0]         entry_count
);
    import sle_pkg::*;

    mem_req_t req;
    rec_t     rd_data;

    sle_seq u_seq
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .key_code(key_code), .new_payload(new_payload),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .position(position),
        .found_payload(found_payload), .entry_count(entry_count),
        .req(req), .rd_data(rd_data)
    );

    sle_ram u_ram
    (
        .clk(clk), .req(req), .rd_data(rd_data)
    );

endmodule
